/* rtl/core/okpr_pkg.sv */
// Package for the opposing-key priority resolver.
// Holds the shared constants, register indexes, action codes and cell control types.
// No dependencies.
`default_nettype none

package okpr_pkg;

  // Sizes of the event fields and of the configuration port.
  localparam int unsigned KeyW        = 8;
  localparam int unsigned ActW        = 2;
  localparam int unsigned PairRegs    = 4;
  localparam int unsigned PairCountW  = 3;
  localparam int unsigned CfgIdxW     = 3;
  localparam int unsigned CfgDataW    = 16;
  localparam int unsigned BufferDepth = 10;

  // Range of basic keycodes that take part in resolution.
  localparam logic [KeyW-1:0] KeyBasicLow  = 8'd4;
  localparam logic [KeyW-1:0] KeyBasicHigh = 8'd164;

  // Result action codes.
  localparam logic [ActW-1:0] ActNone   = 2'd0;
  localparam logic [ActW-1:0] ActAdd    = 2'd1;
  localparam logic [ActW-1:0] ActRemove = 2'd2;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CfgEnable    = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgPairCount = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgPairZero  = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgPairOne   = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgPairTwo   = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgPairThree = 3'd5;

  // Reset values of the configuration registers.
  localparam logic [PairCountW-1:0] PairCountRst = 3'd2;
  localparam logic [CfgDataW-1:0]   PairZeroRst  = 16'd1796;
  localparam logic [CfgDataW-1:0]   PairOneRst   = 16'd1031;
  localparam logic [CfgDataW-1:0]   PairTwoRst   = 16'd0;
  localparam logic [CfgDataW-1:0]   PairThreeRst = 16'd0;

  // Command broadcast to every cell of the held-key chain.
  typedef struct packed {
    logic            remove;
    logic            live_init;
    logic            scan_clear;
    logic [KeyW-1:0] ev_key;
  } okpr_cmd_t;

  // Keys cancelled by the key under scan, one slot per pair register.
  typedef struct packed {
    logic [PairRegs-1:0]           en;
    logic [PairRegs-1:0][KeyW-1:0] key;
  } okpr_cancel_t;

endpackage

`default_nettype wire

/* rtl/core/okpr_in_if.sv */
// Event channel of the opposing-key priority resolver.
// Carries valid, ready and one key event; depends on okpr_pkg.
`default_nettype none

interface okpr_in_if;
  logic                      valid;
  logic                      ready;
  logic [okpr_pkg::KeyW-1:0] key_code;
  logic                      pressed;
  logic                      user_allow;

  modport source (output valid, output key_code, output pressed, output user_allow,
                  input ready);
  modport sink   (input valid, input key_code, input pressed, input user_allow,
                  output ready);
endinterface

`default_nettype wire

/* rtl/core/okpr_out_if.sv */
// Result channel of the opposing-key priority resolver.
// Carries valid, ready and one report action; depends on okpr_pkg.
`default_nettype none

interface okpr_out_if;
  logic                      valid;
  logic                      ready;
  logic [okpr_pkg::ActW-1:0] action;
  logic [okpr_pkg::KeyW-1:0] report_key;
  logic                      last;

  modport source (output valid, output action, output report_key, output last,
                  input ready);
  modport sink   (input valid, input action, input report_key, input last,
                  output ready);
endinterface

`default_nettype wire

/* rtl/core/opposing_key_priority_resolver_unit.sv */
// Opposing-key resolver with last-input priority over a chain of held-key cells.
// Every result is registered. A press gives one remove result per matching pair, one per
// cycle while the output is not stalled. A release walks the chain twice, first a scan that
// clears the live flag of cancelled keys, then a listing of every held key as add or remove.
// One event is in flight at a time and a stalled result holds the walk. Reset clears the
// held count and loads the configuration defaults (resolution off).
`default_nettype none

module opposing_key_priority_resolver_unit #(
  parameter int unsigned BUFFER_DEPTH = okpr_pkg::BufferDepth
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [okpr_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [okpr_pkg::CfgDataW-1:0] cfg_data_i,
  okpr_in_if.sink                            evt_i,
  okpr_out_if.source                         res_o
);

  localparam int unsigned CntW = $clog2(BUFFER_DEPTH + 1);
  localparam int unsigned IdxW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
  localparam int unsigned KeyW = okpr_pkg::KeyW;
  localparam int unsigned NP   = okpr_pkg::PairRegs;

  // Sequencer states.
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_UPDATE = 3'd1;
  localparam logic [2:0] S_SCAN   = 3'd2;
  localparam logic [2:0] S_LIST   = 3'd3;
  localparam logic [2:0] S_PRESS  = 3'd4;
  localparam logic [2:0] S_PASS   = 3'd5;

  // Configuration registers.
  logic                              enable_q;
  logic [okpr_pkg::PairCountW-1:0]   pair_count_q;
  logic [NP-1:0][okpr_pkg::CfgDataW-1:0] pair_q;
  logic [NP-1:0]                     pair_active;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q     <= 1'b0;
      pair_count_q <= okpr_pkg::PairCountRst;
      pair_q[0]    <= okpr_pkg::PairZeroRst;
      pair_q[1]    <= okpr_pkg::PairOneRst;
      pair_q[2]    <= okpr_pkg::PairTwoRst;
      pair_q[3]    <= okpr_pkg::PairThreeRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        okpr_pkg::CfgEnable:    enable_q     <= cfg_data_i[0];
        okpr_pkg::CfgPairCount: pair_count_q <= cfg_data_i[okpr_pkg::PairCountW-1:0];
        okpr_pkg::CfgPairZero:  pair_q[0]    <= cfg_data_i;
        okpr_pkg::CfgPairOne:   pair_q[1]    <= cfg_data_i;
        okpr_pkg::CfgPairTwo:   pair_q[2]    <= cfg_data_i;
        okpr_pkg::CfgPairThree: pair_q[3]    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // A pair register is in use when the pair count reaches past it.
  always_comb begin
    for (int i = 0; i < NP; i++) begin
      pair_active[i] = pair_count_q > okpr_pkg::PairCountW'(i);
    end
  end

  // Control state.
  logic [2:0]      state_q, state_d;
  logic [CntW-1:0] count_q, count_d;
  logic [IdxW-1:0] ptr_q, ptr_d;
  logic [NP-1:0]   mask_q, mask_d;

  // Latched event.
  logic [KeyW-1:0] ev_key_q;
  logic            ev_pressed_q;
  logic            ev_elig_q;
  logic            in_xfer;
  logic            in_elig;

  // Output register.
  logic                      out_valid_q;
  logic [okpr_pkg::ActW-1:0] out_act_q;
  logic [KeyW-1:0]           out_key_q;
  logic                      out_last_q;
  logic                      out_free;
  logic                      emit;
  logic [okpr_pkg::ActW-1:0] emit_act;
  logic [KeyW-1:0]           emit_key;
  logic                      emit_last;

  // Chain signals.
  okpr_pkg::okpr_cmd_t    cmd;
  okpr_pkg::okpr_cancel_t cancel;
  logic [BUFFER_DEPTH-1:0]           valid_w;
  logic [BUFFER_DEPTH-1:0]           load_w;
  logic [BUFFER_DEPTH-1:0]           live_w;
  logic [BUFFER_DEPTH-1:0][KeyW-1:0] key_w;
  logic [BUFFER_DEPTH:0]             rm_chain;

  logic [NP-1:0]   press_mask;
  logic            is_press;
  logic            dup;
  logic            full;
  logic            ins_ok;
  logic [KeyW-1:0] sel_key;
  logic            sel_live;
  logic [KeyW-1:0] press_cancel;
  logic [NP-1:0]   mask_rest;

  assign evt_i.ready = (state_q == S_IDLE);
  assign in_xfer     = evt_i.valid && evt_i.ready;
  assign in_elig     = enable_q && evt_i.user_allow &&
                       (evt_i.key_code >= okpr_pkg::KeyBasicLow) &&
                       (evt_i.key_code <= okpr_pkg::KeyBasicHigh);

  // Pairs whose press key is the event key.
  always_comb begin
    for (int i = 0; i < NP; i++) begin
      press_mask[i] = pair_active[i] && (pair_q[i][KeyW-1:0] == ev_key_q);
    end
  end
  assign is_press = |press_mask;

  // The match chain ends in a flag telling whether the event key is held.
  assign rm_chain[0] = 1'b0;
  assign dup         = rm_chain[BUFFER_DEPTH];
  assign full        = (count_q == CntW'(BUFFER_DEPTH));
  assign ins_ok      = (state_q == S_UPDATE) && ev_elig_q && is_press && ev_pressed_q &&
                       !dup && !full;

  // Row of held-key cells; each takes its neighbor's key when a removal closes the gap.
  for (genvar k = 0; k < BUFFER_DEPTH; k++) begin : g_cell
    logic [KeyW-1:0] nb_key;
    if (k == BUFFER_DEPTH - 1) begin : g_end
      assign nb_key = '0;
    end else begin : g_mid
      assign nb_key = key_w[k+1];
    end
    assign valid_w[k] = count_q > CntW'(k);
    assign load_w[k]  = ins_ok && (count_q == CntW'(k));

    okpr_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .cmd_i    (cmd),
      .cancel_i (cancel),
      .valid_i  (valid_w[k]),
      .load_i   (load_w[k]),
      .nb_key_i (nb_key),
      .rm_i     (rm_chain[k]),
      .rm_o     (rm_chain[k+1]),
      .key_o    (key_w[k]),
      .live_o   (live_w[k])
    );
  end

  // Key and live flag of the slot under the pointer.
  always_comb begin
    sel_key  = '0;
    sel_live = 1'b0;
    for (int k = 0; k < BUFFER_DEPTH; k++) begin
      if (ptr_q == IdxW'(k)) begin
        sel_key  = key_w[k];
        sel_live = live_w[k];
      end
    end
  end

  // Lowest pending pair of a press gives the next remove action.
  always_comb begin
    press_cancel = '0;
    for (int i = NP - 1; i >= 0; i--) begin
      if (mask_q[i]) begin
        press_cancel = pair_q[i][okpr_pkg::CfgDataW-1:KeyW];
      end
    end
  end
  assign mask_rest = mask_q & (mask_q - NP'(1));

  assign out_free = !out_valid_q || res_o.ready;

  // Sequencer: update the chain, then resolve and emit the results of one event.
  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    ptr_d      = ptr_q;
    mask_d     = mask_q;
    cmd        = '0;
    cmd.ev_key = ev_key_q;
    cancel     = '0;
    emit       = 1'b0;
    emit_act   = okpr_pkg::ActNone;
    emit_key   = ev_key_q;
    emit_last  = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          state_d = S_UPDATE;
        end
      end
      S_UPDATE: begin
        cmd.remove    = ev_elig_q && is_press && !ev_pressed_q;
        cmd.live_init = 1'b1;
        if (ins_ok) begin
          count_d = count_q + CntW'(1);
        end else if (cmd.remove && dup) begin
          count_d = count_q - CntW'(1);
        end
        if (!ev_elig_q) begin
          state_d = S_PASS;
        end else if (ev_pressed_q) begin
          mask_d  = press_mask;
          state_d = is_press ? S_PRESS : S_PASS;
        end else if (count_d != '0) begin
          ptr_d   = IdxW'(count_d - CntW'(1));
          state_d = S_SCAN;
        end else begin
          state_d = S_PASS;
        end
      end
      S_SCAN: begin
        cmd.scan_clear = 1'b1;
        for (int i = 0; i < NP; i++) begin
          cancel.en[i]  = sel_live && pair_active[i] && (pair_q[i][KeyW-1:0] == sel_key);
          cancel.key[i] = pair_q[i][okpr_pkg::CfgDataW-1:KeyW];
        end
        if (ptr_q == '0) begin
          state_d = S_LIST;
        end else begin
          ptr_d = ptr_q - IdxW'(1);
        end
      end
      S_LIST: begin
        if (out_free) begin
          emit      = 1'b1;
          emit_act  = sel_live ? okpr_pkg::ActAdd : okpr_pkg::ActRemove;
          emit_key  = sel_key;
          emit_last = (ptr_q == IdxW'(count_q - CntW'(1)));
          if (emit_last) begin
            state_d = S_IDLE;
          end else begin
            ptr_d = ptr_q + IdxW'(1);
          end
        end
      end
      S_PRESS: begin
        if (out_free) begin
          emit      = 1'b1;
          emit_act  = okpr_pkg::ActRemove;
          emit_key  = press_cancel;
          emit_last = (mask_rest == '0);
          mask_d    = mask_rest;
          if (emit_last) begin
            state_d = S_IDLE;
          end
        end
      end
      S_PASS: begin
        if (out_free) begin
          emit      = 1'b1;
          emit_last = 1'b1;
          state_d   = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      ptr_q       <= '0;
      mask_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      ptr_q   <= ptr_d;
      mask_q  <= mask_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Event and result payload registers.
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      ev_key_q     <= evt_i.key_code;
      ev_pressed_q <= evt_i.pressed;
      ev_elig_q    <= in_elig;
    end
    if (emit) begin
      out_act_q  <= emit_act;
      out_key_q  <= emit_key;
      out_last_q <= emit_last;
    end
  end

  assign res_o.valid      = out_valid_q;
  assign res_o.action     = out_act_q;
  assign res_o.report_key = out_key_q;
  assign res_o.last       = out_last_q;

endmodule

`default_nettype wire

/* rtl/core/okpr_cell.sv */
// One slot of the held-key chain: a key, its live flag and the removal shift.
// Depends on okpr_pkg.
`default_nettype none

module okpr_cell (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire okpr_pkg::okpr_cmd_t       cmd_i,
  input  wire okpr_pkg::okpr_cancel_t    cancel_i,
  input  wire logic                      valid_i,
  input  wire logic                      load_i,
  input  wire logic [okpr_pkg::KeyW-1:0] nb_key_i,
  input  wire logic                      rm_i,
  output logic                           rm_o,
  output logic [okpr_pkg::KeyW-1:0]      key_o,
  output logic                           live_o
);

  logic [okpr_pkg::KeyW-1:0] key_q, key_d;
  logic                      live_q, live_d;
  logic                      match;
  logic                      hit;

  // This slot holds the event key, or an older slot does.
  assign match = valid_i && (key_q == cmd_i.ev_key);
  assign rm_o  = rm_i | match;

  // The held key is suppressed by one of the broadcast cancel keys.
  always_comb begin
    hit = 1'b0;
    for (int i = 0; i < okpr_pkg::PairRegs; i++) begin
      if (cancel_i.en[i] && (cancel_i.key[i] == key_q)) begin
        hit = 1'b1;
      end
    end
    hit = hit & valid_i;
  end

  // Append loads the event key; removal takes the neighbor's key to close the gap.
  always_comb begin
    key_d = key_q;
    if (load_i) begin
      key_d = cmd_i.ev_key;
    end else if (cmd_i.remove && rm_o) begin
      key_d = nb_key_i;
    end
  end

  always_comb begin
    live_d = live_q;
    if (cmd_i.live_init) begin
      live_d = 1'b1;
    end else if (cmd_i.scan_clear && hit) begin
      live_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      live_q <= 1'b0;
    end else begin
      live_q <= live_d;
    end
  end

  assign key_o  = key_q;
  assign live_o = live_q;

endmodule

`default_nettype wire
